/* sv/dsc_pkg.sv */
// shared constants, types and helpers for the dictionary segmentation check
package dsc_pkg;

   // symbol and pattern geometry fixed by the request fields
   localparam int SYM_W     = 8;
   localparam int WORD_SYMS = 8;
   localparam int SYM_IDX_W = 3;
   localparam int PAT_W     = SYM_W * WORD_SYMS;
   localparam int LEN_W     = 4;

   // parameter defaults
   localparam int MAX_PATTERN_LEN_DEF = 8;
   localparam int DICT_ENTRIES_DEF    = 512;

   // request function codes
   localparam logic [1:0] FUNC_CLEAR  = 2'd0;
   localparam logic [1:0] FUNC_ADD    = 2'd1;
   localparam logic [1:0] FUNC_SYMBOL = 2'd2;

   // control sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WAIT,
      ST_FINISH
   } state_type;

   // match and reach-select chain passed from cell to cell
   typedef struct packed {
      logic match;
      logic sel;
   } chain_type;

   // controls broadcast to every cell
   typedef struct packed {
      logic sym_shift;
      logic reach_shift;
      logic restart;
   } cell_ctrl_type;

   // reorder pattern so byte a holds the symbol that must sit a places before the newest
   function automatic logic [PAT_W-1:0] align_pattern(logic [PAT_W-1:0] pat,
                                                      logic [LEN_W-1:0] len);
      logic [PAT_W-1:0] res;
      logic [LEN_W-1:0] src;
      res = '0;
      for (int a = 0; a < WORD_SYMS; a++) begin
         src = len - LEN_W'(a) - LEN_W'(1);
         if (LEN_W'(a) < len) begin
            res[a*SYM_W +: SYM_W] = pat[src[SYM_IDX_W-1:0]*SYM_W +: SYM_W];
         end
      end
      return res;
   endfunction

endpackage

/* sv/dictionary_segmentation_check_top.sv */
// dictionary segmentation check: pattern store, window cell chain and sequencer
//
// Decides whether a streamed symbol string splits entirely into stored dictionary
// patterns. A clear or add request leaves the sequencer idle. A symbol request keeps
// the input busy while the pattern ram is walked one entry per cycle (skipped with an
// empty dictionary), each entry checked against the recent-symbol window held in a
// row of MAX_PATTERN_LEN cells. The symbol marked last produces one response carrying
// buildable; the string state then restarts. The pattern store needs no clearing pass
// after reset.
module dictionary_segmentation_check_top #(
   parameter int MAX_PATTERN_LEN = dsc_pkg::MAX_PATTERN_LEN_DEF,
   parameter int DICT_ENTRIES    = dsc_pkg::DICT_ENTRIES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_func,
   input  logic [dsc_pkg::SYM_W-1:0] req_symbol,
   input  logic                      req_last,
   input  logic [dsc_pkg::PAT_W-1:0] req_pattern_symbols,
   input  logic [dsc_pkg::LEN_W-1:0] req_pattern_len,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_buildable
);

   localparam int ADDR_W  = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;
   localparam int CNT_W   = $clog2(DICT_ENTRIES + 1);
   localparam int STORE_W = dsc_pkg::SYM_W * MAX_PATTERN_LEN;
   localparam int RAM_W   = STORE_W + dsc_pkg::LEN_W;

   dsc_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic               rd_valid_ff, rd_valid_in;
   logic               hit_ff, hit_in;
   logic               last_ff, last_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_buildable_ff, rsp_buildable_in;

   logic                          accept, accept_sym, add_ok, scan_end, finish_go, rd_en;
   logic [dsc_pkg::PAT_W-1:0]     aligned;
   logic [RAM_W-1:0]              wr_data, rd_data;
   logic [STORE_W-1:0]            rd_pat;
   logic [dsc_pkg::LEN_W-1:0]     rd_len;
   logic                          hit_now;
   dsc_pkg::cell_ctrl_type        ctrl;
   dsc_pkg::chain_type            chain [MAX_PATTERN_LEN+1];
   logic [dsc_pkg::SYM_W-1:0]     sym_link [MAX_PATTERN_LEN];
   logic                          reach_link [MAX_PATTERN_LEN];

   // request decode
   assign accept     = req_valid & req_ready;
   assign accept_sym = accept & (req_func == dsc_pkg::FUNC_SYMBOL);
   assign add_ok     = accept & (req_func == dsc_pkg::FUNC_ADD)
                     & (req_pattern_len != '0)
                     & (req_pattern_len <= dsc_pkg::LEN_W'(MAX_PATTERN_LEN))
                     & (count_ff < CNT_W'(DICT_ENTRIES));

   assign scan_end  = (CNT_W'(addr_ff) + CNT_W'(1)) == count_ff;
   assign finish_go = (state_ff == dsc_pkg::ST_FINISH)
                    & ~(last_ff & rsp_valid_ff & ~rsp_ready);

   // pattern store
   assign aligned = dsc_pkg::align_pattern(req_pattern_symbols, req_pattern_len);
   assign wr_data = {req_pattern_len, aligned[STORE_W-1:0]};

   dsc_ram #(
      .WIDTH (RAM_W),
      .DEPTH (DICT_ENTRIES)
   ) u_dsc_ram (
      .clock   (clock),
      .wr_en   (add_ok),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign rd_pat = rd_data[STORE_W-1:0];
   assign rd_len = rd_data[RAM_W-1:STORE_W];

   // window cell chain
   assign chain[0].match = 1'b1;
   assign chain[0].sel   = 1'b0;

   for (genvar a = 0; a < MAX_PATTERN_LEN; a++) begin : g_cell
      logic [dsc_pkg::SYM_W-1:0] cell_sym_in;
      logic                      cell_reach_in;
      if (a == 0) begin : g_head
         assign cell_sym_in   = req_symbol;
         assign cell_reach_in = hit_ff;
      end else begin : g_body
         assign cell_sym_in   = sym_link[a-1];
         assign cell_reach_in = reach_link[a-1];
      end
      dsc_cell #(
         .AGE (a)
      ) u_dsc_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .sym_in    (cell_sym_in),
         .reach_in  (cell_reach_in),
         .sym_out   (sym_link[a]),
         .reach_out (reach_link[a]),
         .pat_byte  (rd_pat[a*dsc_pkg::SYM_W +: dsc_pkg::SYM_W]),
         .pat_len   (rd_len),
         .chain_in  (chain[a]),
         .chain_out (chain[a+1])
      );
   end

   assign hit_now = chain[MAX_PATTERN_LEN].match & chain[MAX_PATTERN_LEN].sel;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dsc_pkg::ST_IDLE: begin
            if (accept_sym) begin
               state_in = (count_ff == '0) ? dsc_pkg::ST_FINISH : dsc_pkg::ST_SCAN;
            end
         end
         dsc_pkg::ST_SCAN: begin
            if (scan_end) begin
               state_in = dsc_pkg::ST_WAIT;
            end
         end
         dsc_pkg::ST_WAIT: begin
            state_in = dsc_pkg::ST_FINISH;
         end
         dsc_pkg::ST_FINISH: begin
            if (finish_go) begin
               state_in = dsc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dsc_pkg::ST_IDLE;
         end
      endcase
   end

   // cell controls
   assign ctrl.sym_shift   = accept_sym;
   assign ctrl.reach_shift = finish_go;
   assign ctrl.restart     = finish_go & last_ff;

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      rd_en     = 1'b0;
      case (state_ff)
         dsc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         dsc_pkg::ST_SCAN: begin
            rd_en = 1'b1;
         end
         dsc_pkg::ST_WAIT: begin
            rd_en = 1'b0;
         end
         dsc_pkg::ST_FINISH: begin
            rd_en = 1'b0;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // datapath register updates
   always_comb begin
      count_in         = count_ff;
      addr_in          = addr_ff;
      hit_in           = hit_ff;
      last_in          = last_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_buildable_in = rsp_buildable_ff;
      rd_valid_in      = rd_en;

      if (accept & (req_func == dsc_pkg::FUNC_CLEAR)) begin
         count_in = '0;
      end else if (add_ok) begin
         count_in = count_ff + CNT_W'(1);
      end

      if (accept_sym) begin
         addr_in = '0;
         hit_in  = 1'b0;
         last_in = req_last;
      end else begin
         if (rd_en) begin
            addr_in = addr_ff + ADDR_W'(1);
         end
         if (rd_valid_ff) begin
            hit_in = hit_ff | hit_now;
         end
      end

      if (finish_go & last_ff) begin
         rsp_valid_in     = 1'b1;
         rsp_buildable_in = hit_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dsc_pkg::ST_IDLE;
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff          <= addr_in;
      hit_ff           <= hit_in;
      last_ff          <= last_in;
      rsp_buildable_ff <= rsp_buildable_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_buildable = rsp_buildable_ff;

endmodule

/* sv/dsc_ram.sv */
// generic single-write, single-read ram with registered read data
module dsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/dsc_cell.sv */
// one window cell: holds a recent symbol and its reach bit, compares one pattern byte
module dsc_cell #(
   parameter int AGE = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dsc_pkg::cell_ctrl_type    ctrl,
   input  logic [dsc_pkg::SYM_W-1:0] sym_in,
   input  logic                      reach_in,
   output logic [dsc_pkg::SYM_W-1:0] sym_out,
   output logic                      reach_out,
   input  logic [dsc_pkg::SYM_W-1:0] pat_byte,
   input  logic [dsc_pkg::LEN_W-1:0] pat_len,
   input  dsc_pkg::chain_type        chain_in,
   output dsc_pkg::chain_type        chain_out
);

   localparam logic [dsc_pkg::LEN_W-1:0] AGE_L  = dsc_pkg::LEN_W'(AGE);
   localparam logic [dsc_pkg::LEN_W-1:0] AGE_P1 = dsc_pkg::LEN_W'(AGE + 1);
   localparam logic                      REACH_RST = (AGE == 0);

   logic [dsc_pkg::SYM_W-1:0] sym_ff, sym_in_next;
   logic                      reach_ff, reach_in_next;
   logic                      in_lane, at_len;

   // window shift and restart
   always_comb begin
      sym_in_next   = sym_ff;
      reach_in_next = reach_ff;
      if (ctrl.restart) begin
         sym_in_next   = '0;
         reach_in_next = REACH_RST;
      end else begin
         if (ctrl.sym_shift) begin
            sym_in_next = sym_in;
         end
         if (ctrl.reach_shift) begin
            reach_in_next = reach_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_ff   <= '0;
         reach_ff <= REACH_RST;
      end else begin
         sym_ff   <= sym_in_next;
         reach_ff <= reach_in_next;
      end
   end

   assign sym_out   = sym_ff;
   assign reach_out = reach_ff;

   // byte compare and reach select for the pattern length
   assign in_lane = AGE_L < pat_len;
   assign at_len  = AGE_P1 == pat_len;

   assign chain_out.match = chain_in.match & (~in_lane | (pat_byte == sym_ff));
   assign chain_out.sel   = chain_in.sel | (at_len & reach_ff);

endmodule

/* sv/dsc_checker.sv */
// port-level checks for the dictionary segmentation check, bound to the top level
module dsc_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic [1:0]                req_func,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic                      rsp_buildable
);

   // no response right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled response holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_buildable)))
      else $error("stalled response changed");

   // dictionary requests never create a response
   a_dict_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_func != dsc_pkg::FUNC_SYMBOL && !rsp_valid)
      |=> !rsp_valid)
      else $error("response after a dictionary request");

   // dictionary requests do not stall the input
   a_dict_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_func != dsc_pkg::FUNC_SYMBOL) |=> req_ready)
      else $error("dictionary request stalled the input");

   // a symbol request keeps the input busy while the dictionary is walked
   a_symbol_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_func == dsc_pkg::FUNC_SYMBOL) |=> !req_ready)
      else $error("input ready during a symbol request");

endmodule

bind dictionary_segmentation_check_top dsc_checker u_dsc_checker (.*);

/* dv/tb_dictionary_segmentation_check_top.sv */
// testbench for the dictionary segmentation check: directed table, random strings, scoreboard
`timescale 1ns / 1ps

module tb_dictionary_segmentation_check_top;
   import dsc_pkg::*;

   localparam int MAX_LEN       = MAX_PATTERN_LEN_DEF;
   localparam int DICT_N        = DICT_ENTRIES_DEF;
   localparam int RESET_CYCLES  = 9;
   localparam int SETTLE_CYCLES = DICT_N + 100;
   localparam int HOLD_CYCLES   = 400;
   localparam int STALL_LIMIT   = 20000;
   localparam int REPORT_LIMIT  = 10;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   // one row of the directed table
   typedef struct packed {
      logic [1:0]       func;
      logic [SYM_W-1:0] symbol;
      logic             last;
      logic [PAT_W-1:0] pat;
      logic [LEN_W-1:0] plen;
      logic             typed;
      logic             typed_value;
   } seg_request_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [1:0]       req_func = FUNC_CLEAR;
   logic [SYM_W-1:0] req_symbol = '0;
   logic             req_last = 1'b0;
   logic [PAT_W-1:0] req_pattern_symbols = '0;
   logic [LEN_W-1:0] req_pattern_len = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic             rsp_buildable;

   // dictionary and string state of the predictor
   logic [PAT_W-1:0] dict_pat [0:DICT_N-1];
   logic [LEN_W-1:0] dict_len [0:DICT_N-1];
   int               dict_count = 0;
   logic [PAT_W-1:0] window_syms = '0;
   logic [MAX_LEN:0] reach_ends = {{MAX_LEN{1'b0}}, 1'b1};

   logic             buildable_expected_q [$];
   logic [SYM_W-1:0] string_syms [$];
   seg_request_type  directed_rows [0:22];

   int   items_sent = 0;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   noise_pct = 10;
   int   fail_count = 0;
   int   stall_cycles = 0;
   int   hold_left = 0;
   logic hold_toggle = 1'b0;
   logic hold_seen = 1'b0;

   dictionary_segmentation_check_top #(
      .MAX_PATTERN_LEN(MAX_LEN),
      .DICT_ENTRIES   (DICT_N)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_symbol         (req_symbol),
      .req_last           (req_last),
      .req_pattern_symbols(req_pattern_symbols),
      .req_pattern_len    (req_pattern_len),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_buildable      (rsp_buildable)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [PAT_W-1:0] keep_low_bytes(input int n);
      if (n >= WORD_SYMS) return '1;
      return (64'd1 << (SYM_W * n)) - 64'd1;
   endfunction

   // mostly a three-letter alphabet so that strings and patterns line up
   function automatic logic [SYM_W-1:0] pick_sym();
      if ($urandom_range(9) < 8) return 8'h61 + 8'($urandom_range(2));
      return 8'($urandom_range(255));
   endfunction

   // sliding reachability update for one request
   task automatic advance_segmentation(input logic [1:0] f, input logic [SYM_W-1:0] s,
                                       input logic l, input logic [PAT_W-1:0] p,
                                       input logic [LEN_W-1:0] n,
                                       output logic produced, output logic built);
      int               ln;
      logic [PAT_W-1:0] tail;
      logic             hit;
      produced = 1'b0;
      built    = 1'b0;
      hit      = 1'b0;
      case (f)
         FUNC_CLEAR: begin
            dict_count = 0;
         end
         FUNC_ADD: begin
            if (n >= 1 && n <= MAX_LEN && dict_count < DICT_N) begin
               dict_pat[dict_count] = p & keep_low_bytes(int'(n));
               dict_len[dict_count] = n;
               dict_count++;
            end
         end
         FUNC_SYMBOL: begin
            window_syms = {s, window_syms[PAT_W-1:SYM_W]};
            for (int i = 0; i < dict_count; i++) begin
               if (!hit) begin
                  ln = int'(dict_len[i]);
                  if (reach_ends[ln-1]) begin
                     tail = window_syms >> (PAT_W - SYM_W * ln);
                     if (tail == dict_pat[i]) hit = 1'b1;
                  end
               end
            end
            reach_ends = {reach_ends[MAX_LEN-1:0], hit};
            if (l) begin
               produced    = 1'b1;
               built       = hit;
               window_syms = '0;
               reach_ends  = {{MAX_LEN{1'b0}}, 1'b1};
            end
         end
         default: begin
         end
      endcase
   endtask

   // offer one request, wait for the handshake, then record what it should produce
   task automatic offer_request(input logic [1:0] f, input logic [SYM_W-1:0] s,
                                input logic l, input logic [PAT_W-1:0] p,
                                input logic [LEN_W-1:0] n,
                                input logic typed, input logic typed_value);
      int   gap;
      logic produced;
      logic built;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_func            <= f;
      req_symbol          <= s;
      req_last            <= l;
      req_pattern_symbols <= p;
      req_pattern_len     <= n;
      do @(posedge clock); while (!req_ready);
      advance_segmentation(f, s, l, p, n, produced, built);
      if (produced) buildable_expected_q = {buildable_expected_q, typed ? typed_value : built};
      items_sent++;
   endtask

   task automatic add_random_pattern(input int lo, input int hi);
      int               len;
      logic [PAT_W-1:0] pat;
      if ($urandom_range(2) == 0) len = $urandom_range(hi, lo);
      else len = $urandom_range((lo + 2 < hi) ? lo + 2 : hi, lo);
      pat = ($urandom_range(1) == 0) ? {$urandom, $urandom} : '0;
      for (int b = 0; b < len; b++) pat[b*SYM_W +: SYM_W] = pick_sym();
      offer_request(FUNC_ADD, 8'($urandom), 1'($urandom), pat, 4'(len), 1'b0, 1'b0);
   endtask

   // requests the block ignores, bad lengths, and dictionary changes mid-string
   task automatic send_noise();
      case ($urandom_range(9))
         0, 1, 2, 3, 4: begin
            offer_request(FUNC_UNUSED, 8'($urandom), 1'($urandom), {$urandom, $urandom},
                          4'($urandom), 1'b0, 1'b0);
         end
         5, 6, 7: begin
            offer_request(FUNC_ADD, 8'($urandom), 1'($urandom), {$urandom, $urandom},
                          ($urandom_range(1) == 0) ? 4'd0 : 4'($urandom_range(15, 9)),
                          1'b0, 1'b0);
         end
         8: begin
            offer_request(FUNC_CLEAR, 8'($urandom), 1'($urandom), {$urandom, $urandom},
                          4'($urandom), 1'b0, 1'b0);
         end
         default: begin
            add_random_pattern(1, MAX_LEN);
         end
      endcase
   endtask

   task automatic append_dict_pattern(input int idx);
      for (int b = 0; b < int'(dict_len[idx]); b++)
         string_syms = {string_syms, dict_pat[idx][b*SYM_W +: SYM_W]};
   endtask

   task automatic send_string();
      for (int k = 0; k < string_syms.size(); k++) begin
         if ($urandom_range(99) < noise_pct) send_noise();
         offer_request(FUNC_SYMBOL, string_syms[k], k == string_syms.size() - 1,
                       {$urandom, $urandom}, 4'($urandom), 1'b0, 1'b0);
      end
   endtask

   // small dictionary, then strings built from it, corrupted, or plain noise
   task automatic run_episode();
      int kind;
      int pos;
      if ($urandom_range(9) < 7 || dict_count == 0) begin
         offer_request(FUNC_CLEAR, 8'($urandom), 1'($urandom), {$urandom, $urandom},
                       4'($urandom), 1'b0, 1'b0);
         repeat ($urandom_range(6, 1)) add_random_pattern(1, MAX_LEN);
      end
      repeat ($urandom_range(4, 1)) begin
         kind = $urandom_range(99);
         string_syms.delete();
         if (kind < 85 && dict_count > 0) begin
            repeat ($urandom_range(4, 1)) append_dict_pattern($urandom_range(dict_count - 1));
            if (kind >= 65) begin
               pos = $urandom_range(string_syms.size() - 1);
               string_syms[pos] = pick_sym();
            end
         end else begin
            repeat ($urandom_range(10, 1)) string_syms = {string_syms, pick_sym()};
         end
         send_string();
      end
   endtask

   // fill every entry, offer more than fit, and test strings against the full store
   task automatic fill_dictionary_test();
      noise_pct = 0;
      offer_request(FUNC_CLEAR, 8'h00, 1'b0, '0, 4'd0, 1'b0, 1'b0);
      repeat (DICT_N + 2) add_random_pattern(2, MAX_LEN);
      offer_request(FUNC_ADD, 8'h00, 1'b0, 64'h7A, 4'd1, 1'b0, 1'b0);
      string_syms.delete();
      string_syms = {string_syms, 8'h7A};
      send_string();
      repeat (3) begin
         string_syms.delete();
         repeat ($urandom_range(2, 1)) append_dict_pattern($urandom_range(DICT_N - 1));
         send_string();
      end
      string_syms.delete();
      append_dict_pattern(DICT_N - 1);
      send_string();
      offer_request(FUNC_CLEAR, 8'h00, 1'b0, '0, 4'd0, 1'b0, 1'b0);
      string_syms.delete();
      string_syms = {string_syms, 8'h61};
      send_string();
   endtask

   // sender stops until every response is in and the block has gone quiet
   task automatic wait_for_responses();
      req_valid <= 1'b0;
      while (buildable_expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // response side: random backpressure plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // scoreboard
   always @(posedge clock) begin
      logic want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (buildable_expected_q.size() == 0) begin
            if (fail_count < REPORT_LIMIT)
               $display("response with nothing pending: buildable %0d", rsp_buildable);
            fail_count++;
         end else begin
            want = buildable_expected_q.pop_front();
            if (rsp_buildable !== want) begin
               if (fail_count < REPORT_LIMIT)
                  $display("buildable mismatch: expected %0d, got %0d", want, rsp_buildable);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      // func, symbol, last, pattern, length, typed, typed value
      directed_rows[0]  = '{FUNC_SYMBOL, 8'h61, 1'b1, 64'h0, 4'd0, 1'b1, 1'b0};
      directed_rows[1]  = '{FUNC_ADD, 8'h00, 1'b0, 64'hFFFF_FFFF_FFFF_FF61, 4'd1, 1'b0, 1'b0};
      directed_rows[2]  = '{FUNC_SYMBOL, 8'h61, 1'b1, 64'h0, 4'd0, 1'b1, 1'b1};
      directed_rows[3]  = '{FUNC_ADD, 8'h00, 1'b0, 64'h62, 4'd0, 1'b0, 1'b0};
      directed_rows[4]  = '{FUNC_ADD, 8'h00, 1'b0, 64'h62, 4'd9, 1'b0, 1'b0};
      directed_rows[5]  = '{FUNC_ADD, 8'hFF, 1'b1, '1, 4'd15, 1'b0, 1'b0};
      directed_rows[6]  = '{FUNC_SYMBOL, 8'h62, 1'b1, 64'h0, 4'd0, 1'b1, 1'b0};
      directed_rows[7]  = '{FUNC_CLEAR, 8'hFF, 1'b1, '1, 4'd15, 1'b0, 1'b0};
      directed_rows[8]  = '{FUNC_ADD, 8'h00, 1'b0, '1, 4'd8, 1'b0, 1'b0};
      directed_rows[9]  = '{FUNC_ADD, 8'h00, 1'b0, '1, 4'd8, 1'b0, 1'b0};
      directed_rows[10] = '{FUNC_SYMBOL, 8'hFF, 1'b0, 64'h0, 4'd0, 1'b0, 1'b0};
      directed_rows[11] = '{FUNC_SYMBOL, 8'hFF, 1'b0, 64'h0, 4'd0, 1'b0, 1'b0};
      directed_rows[12] = '{FUNC_SYMBOL, 8'hFF, 1'b0, 64'h0, 4'd0, 1'b0, 1'b0};
      directed_rows[13] = '{FUNC_SYMBOL, 8'hFF, 1'b0, 64'h0, 4'd0, 1'b0, 1'b0};
      directed_rows[14] = '{FUNC_SYMBOL, 8'hFF, 1'b0, 64'h0, 4'd0, 1'b0, 1'b0};
      directed_rows[15] = '{FUNC_SYMBOL, 8'hFF, 1'b0, 64'h0, 4'd0, 1'b0, 1'b0};
      directed_rows[16] = '{FUNC_SYMBOL, 8'hFF, 1'b0, 64'h0, 4'd0, 1'b0, 1'b0};
      directed_rows[17] = '{FUNC_SYMBOL, 8'hFF, 1'b1, 64'h0, 4'd0, 1'b1, 1'b1};
      directed_rows[18] = '{FUNC_UNUSED, 8'h00, 1'b1, 64'h0, 4'd8, 1'b0, 1'b0};
      directed_rows[19] = '{FUNC_SYMBOL, 8'h00, 1'b0, 64'h0, 4'd0, 1'b0, 1'b0};
      directed_rows[20] = '{FUNC_CLEAR, 8'h00, 1'b0, 64'h0, 4'd0, 1'b0, 1'b0};
      directed_rows[21] = '{FUNC_ADD, 8'h00, 1'b0, 64'h0, 4'd2, 1'b0, 1'b0};
      directed_rows[22] = '{FUNC_SYMBOL, 8'h00, 1'b1, 64'h0, 4'd0, 1'b0, 1'b0};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // phase one: sender mostly busy, receiver mostly stalled
      send_idle_pct = 15;
      recv_idle_pct <= 88;
      foreach (directed_rows[r])
         offer_request(directed_rows[r].func, directed_rows[r].symbol, directed_rows[r].last,
                       directed_rows[r].pat, directed_rows[r].plen,
                       directed_rows[r].typed, directed_rows[r].typed_value);
      while (items_sent < 220) run_episode();
      wait_for_responses();

      // phase two: roles swapped
      send_idle_pct = 88;
      recv_idle_pct <= 15;
      while (items_sent < 420) run_episode();
      wait_for_responses();

      // phase three: no idling, long receiver hold-off at the start
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      hold_toggle <= ~hold_toggle;
      while (items_sent < 640) run_episode();
      wait_for_responses();

      fill_dictionary_test();
      wait_for_responses();

      if (fail_count == 0 && buildable_expected_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
